[src/assert_macros.svh]
// Assertion macros for the checker file of the frame receiver.
// Depends on nothing; callers provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SFR_ASSERT_ON(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Concurrent assertion on the local clk and rst_n.
`define SFR_ASSERT(lbl, prop, msg) \
  `SFR_ASSERT_ON(lbl, clk, rst_n, prop, msg)

`endif

[src/sfr_pkg.sv]
// Types and constants of the serial frame receiver.
// Used by the channel interfaces, the top level and the checker.
package sfr_pkg;

  localparam int POS_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int END_W   = 9;
  localparam int SIL_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
  localparam logic [END_W-1:0]  END_OFFSET = 9'd8;
  localparam logic [SIL_W-1:0]  SIL_MAX    = 16'hFFFF;
  localparam logic [SIL_W-1:0]  SIL_LIMIT_RST = 16'd2;

  // Header positions; all but the summed range have header checks of their own.
  localparam logic [POS_W-1:0] POS_SYNC   = 8'd1;
  localparam logic [POS_W-1:0] POS_ADDR   = 8'd2;
  localparam logic [POS_W-1:0] POS_SUM_LO = 8'd3;
  localparam logic [POS_W-1:0] POS_SUM_HI = 8'd5;
  localparam logic [POS_W-1:0] POS_CHECK  = 8'd6;
  localparam logic [POS_W-1:0] POS_LEN    = 8'd7;

  typedef enum logic [0:0] {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_TAKEN   = 3'd1,
    ST_REJECT  = 3'd2,
    ST_DONE    = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_ADDRESS  = 2'd0,
    REG_SILENCE_LIMIT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    byte_position;
    logic [BYTE_W-1:0]   data_byte;
    logic [END_W-1:0]    frame_end;
  } result_t;

endpackage

[src/sfr_if.sv]
// Valid/ready channel interfaces of the serial frame receiver.
// Depends on sfr_pkg for field widths and codes.
interface sfr_in_if import sfr_pkg::*; ();
  logic              valid;
  logic              ready;
  cmd_t              cmd;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface sfr_out_if import sfr_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [POS_W-1:0]  byte_position;
  logic [BYTE_W-1:0] data_byte;
  logic [END_W-1:0]  frame_end;

  modport source (output valid, output status, output byte_position,
                  output data_byte, output frame_end, input ready);
  modport sink   (input valid, input status, input byte_position,
                  input data_byte, input frame_end, output ready);
endinterface

interface sfr_cfg_if import sfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/serial_frame_receiver.sv]
// Serial frame receiver: header checks, frame end tracking, silence timeout.
// Depends on sfr_pkg and the channel interfaces in sfr_if.sv.
//
//   channel  | dir | payload                                       | ready
//   ---------+-----+-----------------------------------------------+-----------------
//   in_ch    | in  | cmd, rx_byte                                  | out reg free
//   out_ch   | out | status, byte_position, data_byte, frame_end   | from consumer
//   cfg_ch   | in  | index, data (node_address, silence_limit)     | high out of reset
//
// One item per cycle unless out_ch stalls: each byte or tick is decoded against
// the frame state in a single pass and its result lands in the output register
// on the same edge. The output register is the only buffer; a new item is taken
// whenever it is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous) clears the frame state, sets node_address to
// 0 and silence_limit to 2, empties the output register and holds both readies low.
// A stall on out_ch holds the result and stalls in_ch; no item is dropped.
module serial_frame_receiver
  import sfr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  sfr_in_if.sink    in_ch,
  sfr_out_if.source out_ch,
  sfr_cfg_if.sink   cfg_ch
);

  // Configuration registers.
  logic [BYTE_W-1:0] node_address_r;
  logic [SIL_W-1:0]  silence_limit_r;

  // Frame state.
  logic [POS_W-1:0]  write_pos_r,  write_pos_nxt;
  logic [BYTE_W-1:0] header_sum_r, header_sum_nxt;
  logic [END_W-1:0]  end_pos_r,    end_pos_nxt;
  logic [SIL_W-1:0]  silence_r,    silence_nxt;

  // Output register.
  logic    out_valid_r;
  result_t result_r, result_nxt;

  logic              in_take;
  logic [POS_W-1:0]  next_pos;
  logic [SIL_W-1:0]  sil_inc;
  logic              fail;
  logic              checked;
  logic              timeout;

  // Take a new item when the output register is empty or drains this cycle.
  assign in_ch.ready  = rst_n && (!out_valid_r || out_ch.ready);
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = rst_n;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = result_r.status;
  assign out_ch.byte_position = result_r.byte_position;
  assign out_ch.data_byte     = result_r.data_byte;
  assign out_ch.frame_end     = result_r.frame_end;

  assign next_pos = write_pos_r + 8'd1;
  assign sil_inc  = (silence_r == SIL_MAX) ? silence_r : silence_r + 16'd1;
  assign timeout  = sil_inc > silence_limit_r;

  // Decode one item against the frame state.
  always_comb begin
    write_pos_nxt  = write_pos_r;
    header_sum_nxt = header_sum_r;
    end_pos_nxt    = end_pos_r;
    silence_nxt    = silence_r;
    fail           = 1'b0;
    checked        = 1'b0;
    result_nxt     = result_r;

    if (in_ch.cmd == CMD_TICK) begin
      // Count silence, saturating; restart reception once past the limit.
      silence_nxt   = sil_inc;
      write_pos_nxt = timeout ? '0 : write_pos_r;
      result_nxt.status        = timeout ? ST_TIMEOUT : ST_NONE;
      result_nxt.byte_position = write_pos_nxt;
      result_nxt.data_byte     = '0;
      result_nxt.frame_end     = end_pos_r;
    end else begin
      silence_nxt = '0;
      case (next_pos) inside
        POS_SYNC: begin
          checked = 1'b1;
          fail    = in_ch.rx_byte != SYNC_BYTE;
        end
        POS_ADDR: begin
          checked = 1'b1;
          fail    = in_ch.rx_byte != node_address_r;
          if (!fail) begin
            header_sum_nxt = in_ch.rx_byte;
          end
        end
        [POS_SUM_LO:POS_SUM_HI]: begin
          header_sum_nxt = header_sum_r + in_ch.rx_byte;
        end
        POS_CHECK: begin
          checked = 1'b1;
          fail    = in_ch.rx_byte != header_sum_r;
        end
        POS_LEN: begin
          checked     = 1'b1;
          end_pos_nxt = {1'b0, in_ch.rx_byte} + END_OFFSET;
        end
        default: begin
        end
      endcase

      write_pos_nxt = fail ? '0 : next_pos;
      // Completion only on positions without a header check of their own.
      if (fail) begin
        result_nxt.status = ST_REJECT;
      end else if (!checked && ({1'b0, next_pos} == end_pos_r)) begin
        result_nxt.status = ST_DONE;
      end else begin
        result_nxt.status = ST_TAKEN;
      end
      result_nxt.byte_position = write_pos_r;
      result_nxt.data_byte     = in_ch.rx_byte;
      result_nxt.frame_end     = end_pos_nxt;
    end
  end

  // Frame state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pos_r     <= '0;
      header_sum_r    <= '0;
      end_pos_r       <= '0;
      silence_r       <= '0;
      node_address_r  <= '0;
      silence_limit_r <= SIL_LIMIT_RST;
    end else begin
      if (in_take) begin
        write_pos_r  <= write_pos_nxt;
        header_sum_r <= header_sum_nxt;
        end_pos_r    <= end_pos_nxt;
        silence_r    <= silence_nxt;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_NODE_ADDRESS:  node_address_r  <= cfg_ch.data[BYTE_W-1:0];
          REG_SILENCE_LIMIT: silence_limit_r <= cfg_ch.data[SIL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Output register: load on take, drop valid once drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      result_r <= result_nxt;
    end
  end

endmodule

[src/sfr_checker.sv]
// Port-level checker for serial_frame_receiver, attached by bind.
// Depends on sfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfr_checker
  import sfr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input cmd_t              in_cmd,
  input logic [BYTE_W-1:0] in_rx_byte,
  input logic              out_valid,
  input logic              out_ready,
  input status_t           out_status,
  input logic [POS_W-1:0]  out_byte_position,
  input logic [BYTE_W-1:0] out_data_byte,
  input logic [END_W-1:0]  out_frame_end
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // Hold a stalled result.
  `SFR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_status), "result dropped while stalled")

  // A tick yields a result with no data byte and never a byte status.
  `SFR_ASSERT(a_tick_result, in_acc && in_cmd == CMD_TICK |=> out_valid && out_data_byte == '0 && (out_status == ST_NONE || out_status == ST_TIMEOUT), "bad tick result")

  // A byte is echoed with a byte status.
  `SFR_ASSERT(a_byte_echo, in_acc && in_cmd == CMD_BYTE |=> out_valid && out_data_byte == $past(in_rx_byte) && (out_status == ST_TAKEN || out_status == ST_REJECT || out_status == ST_DONE), "bad byte result")

  // Completion lands one position before the frame end.
  `SFR_ASSERT(a_done_pos, out_valid && out_status == ST_DONE |-> !out_frame_end[END_W-1] && out_frame_end[POS_W-1:0] == out_byte_position + 8'd1, "completion off frame end")

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_cmd            (in_ch.cmd),
  .in_rx_byte        (in_ch.rx_byte),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_byte_position (out_ch.byte_position),
  .out_data_byte     (out_ch.data_byte),
  .out_frame_end     (out_ch.frame_end)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for serial_frame_receiver: header checks, frame end, silence timeout.
// Depends on sfr_pkg, the channel interfaces in sfr_if.sv and the receiver RTL.
module tb_top;
  import sfr_pkg::*;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int RANDOM_ITEMS = 650;
  localparam int PHASES       = 6;
  localparam logic [SIL_W-1:0] LONG_QUIET = 16'h0100;

  logic clk = 1'b0;
  logic rst_n;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();
  sfr_cfg_if cfg_ch ();

  serial_frame_receiver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 10 ns period: low half, then high half.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Receiver mirror. Holds its own copy of the frame state and both registers,
  // advanced once per accepted item by frame_rx_step.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]  rx_pos       = '0;
  logic [BYTE_W-1:0] rx_sum       = '0;
  logic [END_W-1:0]  rx_end       = '0;
  logic [SIL_W-1:0]  rx_quiet     = '0;
  logic [BYTE_W-1:0] rx_addr      = '0;
  logic [SIL_W-1:0]  rx_quiet_max = SIL_LIMIT_RST;

  result_t pending_echoes [$];   // one entry per accepted item, oldest first
  int      mismatches = 0;
  int      items_sent = 0;
  int      cycles     = 0;

  bit src_steady  = 1'b0;   // sender sends back to back while set
  bit sink_steady = 1'b0;   // consumer takes every result at once while set
  bit fast_mode   = 1'b0;   // force both sides to full rate

  // Compute the result of one item and advance the mirrored frame state.
  function automatic result_t frame_rx_step(cmd_t c, logic [BYTE_W-1:0] b);
    result_t          r;
    logic [POS_W-1:0] nxt;
    logic             bad;
    logic             fin;
    r = '0;
    if (c == CMD_TICK) begin
      // Count silence, saturating; past the limit, drop back to position 0 on every tick.
      if (rx_quiet != SIL_MAX) rx_quiet = rx_quiet + 1'b1;
      r.status = ST_NONE;
      if (rx_quiet > rx_quiet_max) begin
        rx_pos   = '0;
        r.status = ST_TIMEOUT;
      end
      r.byte_position = rx_pos;
      r.data_byte     = '0;
    end else begin
      // Checks look at the advanced position; the echo carries the old one.
      nxt      = rx_pos + 1'b1;
      bad      = 1'b0;
      fin      = 1'b0;
      rx_quiet = '0;
      if (nxt == POS_SYNC) begin
        bad = (b != SYNC_BYTE);
      end else if (nxt == POS_ADDR) begin
        if (b == rx_addr) rx_sum = b;
        else bad = 1'b1;
      end else if (nxt >= POS_SUM_LO && nxt <= POS_SUM_HI) begin
        rx_sum = rx_sum + b;
      end else if (nxt == POS_CHECK) begin
        bad = (b != rx_sum);
      end else if (nxt == POS_LEN) begin
        rx_end = {1'b0, b} + END_OFFSET;
      end
      // Completion only where no header check applies.
      if (nxt != POS_SYNC && nxt != POS_ADDR && nxt != POS_CHECK && nxt != POS_LEN &&
          {1'b0, nxt} == rx_end)
        fin = 1'b1;
      r.status        = bad ? ST_REJECT : (fin ? ST_DONE : ST_TAKEN);
      r.byte_position = rx_pos;
      r.data_byte     = b;
      rx_pos          = bad ? '0 : nxt;
    end
    r.frame_end = rx_end;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge. Check results first,
  // then apply register writes, then queue the result of a newly taken item.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_echoes.size() == 0) begin
          report_mismatch("result with none pending, status", out_ch.status, ST_NONE);
        end else begin
          want = pending_echoes.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", out_ch.status, want.status);
          if (out_ch.byte_position !== want.byte_position)
            report_mismatch("byte_position", out_ch.byte_position, want.byte_position);
          if (out_ch.data_byte !== want.data_byte)
            report_mismatch("data_byte", out_ch.data_byte, want.data_byte);
          if (out_ch.frame_end !== want.frame_end)
            report_mismatch("frame_end", out_ch.frame_end, want.frame_end);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_reg_t'(cfg_ch.index) == REG_NODE_ADDRESS) rx_addr = cfg_ch.data[BYTE_W-1:0];
        else if (cfg_reg_t'(cfg_ch.index) == REG_SILENCE_LIMIT) rx_quiet_max = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready)
        pending_echoes.push_back(frame_rx_step(in_ch.cmd, in_ch.rx_byte));
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Consumer: drop ready for a random stall, possibly none, before each result, with steady stretches.
  initial begin : echo_sink
    int stall;
    int taken;
    taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      stall = (fast_mode || sink_steady) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      taken++;
      if (taken % 50 == 0) sink_steady = ($urandom_range(0, 3) == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Hold off for a random gap, possibly none, then present one item and wait for it to be taken.
  task automatic send_item(cmd_t c, logic [BYTE_W-1:0] b);
    int gap;
    gap = (fast_mode || src_steady) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= c;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b);
    send_item(CMD_BYTE, b);
  endtask

  // The byte field is ignored on ticks; drive noise on it anyway.
  task automatic send_tick();
    send_item(CMD_TICK, BYTE_W'($urandom_range(0, 255)));
  endtask

  // Drop valid and hold until every result has come back, then let the pipe drain.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_echoes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Enough consecutive ticks to force a timeout, which returns the position to 0.
  task automatic resync(int quiet_max);
    repeat (quiet_max + 1) send_tick();
  endtask

  // One frame: sync, address, three summed bytes, header sum, length, body.
  // bad_at >= 0 flips bits in that header byte after the sum is formed.
  task automatic send_frame(logic [BYTE_W-1:0] addr, int bad_at, int len, int body_n,
                            int tick_odds);
    logic [BYTE_W-1:0] hdr [6];
    hdr[0] = SYNC_BYTE;
    hdr[1] = addr;
    hdr[2] = BYTE_W'($urandom_range(0, 255));
    hdr[3] = BYTE_W'($urandom_range(0, 255));
    hdr[4] = BYTE_W'($urandom_range(0, 255));
    hdr[5] = hdr[1] + hdr[2] + hdr[3] + hdr[4];
    if (bad_at >= 0) hdr[bad_at] = hdr[bad_at] ^ BYTE_W'($urandom_range(1, 255));
    for (int i = 0; i < 6; i++) begin
      if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1) send_tick();
      send_byte(hdr[i]);
    end
    send_byte(len[BYTE_W-1:0]);
    for (int i = 0; i < body_n; i++) begin
      if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1) send_tick();
      send_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default registers: timeout at the third tick, rejected sync, a complete
  // shortest frame with extreme bytes, advance past the end, bad header sum, bad address.
  task automatic test_directed();
    repeat (3) send_tick();
    send_byte(8'h00);
    send_byte(SYNC_BYTE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h80);        // header sum of 0x00 + 0xFF + 0x01 + 0x80
    send_byte(8'h00);        // length 0: the end lands on the next byte
    send_byte(8'hAA);
    send_byte(8'h12);
    repeat (3) send_tick();
    send_byte(SYNC_BYTE);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'h07);        // wrong sum: reject
    send_byte(8'h55);
    send_byte(8'h01);        // wrong address: reject
    settle();
  endtask

  // Top address, and a length whose end is past 255: run the position through
  // the wrap and check that the sync check comes back.
  task automatic test_frame_end_wrap();
    write_reg(REG_NODE_ADDRESS, CFG_DATA_W'(8'hFF));
    resync(SIL_LIMIT_RST);
    send_frame(8'hFF, -1, 255, 249, 0);
    send_byte(SYNC_BYTE);
    send_byte(8'hFE);
    settle();
  endtask

  // Several register settings; mostly well-formed frames with random content,
  // some broken, plus noise and bursts of ticks.
  task automatic test_random_frames();
    logic [BYTE_W-1:0] addr;
    int quiet_max;
    int stop_at;
    int pick;
    int len;
    int body_n;
    stop_at = items_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin addr = 8'h00;     quiet_max = 0; end
        1: begin addr = 8'hFF;     quiet_max = 1; end
        2: begin addr = SYNC_BYTE; quiet_max = 2; end
        3: begin addr = BYTE_W'($urandom_range(0, 255)); quiet_max = 3; end
        4: begin addr = BYTE_W'($urandom_range(0, 255)); quiet_max = 7; end
        default: begin
          addr      = BYTE_W'($urandom_range(0, 255));
          quiet_max = $urandom_range(0, 5);
        end
      endcase
      settle();
      write_reg(REG_NODE_ADDRESS, CFG_DATA_W'(addr));
      write_reg(REG_SILENCE_LIMIT, CFG_DATA_W'(quiet_max));
      stop_at += RANDOM_ITEMS / PHASES;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 15) == 0) src_steady = ($urandom_range(0, 2) == 0);
        // Now and then hold the sender until every result is back.
        if ($urandom_range(0, 49) == 0) settle();
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
          body_n = len + 1 + $urandom_range(0, 3);
          if (body_n > 48) body_n = 48;
          if ($urandom_range(0, 1) == 0) resync(quiet_max);
          send_frame(addr, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : -1,
                     len, body_n, 12);
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
              0, 1: send_tick();
              2: send_byte(SYNC_BYTE);
              3: send_byte(addr);
              default: send_byte(BYTE_W'($urandom_range(0, 255)));
            endcase
          end
        end else begin
          repeat ($urandom_range(1, quiet_max + 2)) send_tick();
        end
      end
    end
    src_steady = 1'b0;
    settle();
  endtask

  // A limit with its upper byte set: no timeout up to the limit, a timeout on
  // each tick past it, and a byte that clears the count.
  task automatic test_long_silence();
    write_reg(REG_SILENCE_LIMIT, LONG_QUIET);
    fast_mode = 1'b1;
    repeat (int'(LONG_QUIET) + 2) send_tick();
    send_byte(SYNC_BYTE);
    send_tick();
    fast_mode = 1'b0;
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_BYTE;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_NODE_ADDRESS;
    cfg_ch.data   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed();
    test_frame_end_wrap();
    test_random_frames();
    test_long_silence();

    // Wait out the last results, then a few cycles for anything stray.
    while (pending_echoes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
